// ===== hdl/cosine_template_matcher_unit_assert.svh =====
// Assertion macros used by the control module of the template matcher
`ifndef COSINE_TEMPLATE_MATCHER_UNIT_ASSERT_SVH
`define COSINE_TEMPLATE_MATCHER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define CMT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define CMT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CMT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define CMT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/cmt_pkg.sv =====
package cmt_pkg;

  localparam int MAX_TEMPLATES = 16;
  localparam int IDX_W = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1;
  localparam int CNT_W = $clog2(MAX_TEMPLATES + 1);
  localparam int USER_W = 8;
  localparam int FEAT_W = 24;
  localparam int SCORE_W = 16;
  localparam int ROOT_W = 32;
  localparam int RAD_W = 2 * ROOT_W;
  localparam int ENTRY_W = USER_W + 2 * FEAT_W + ROOT_W;
  localparam int DIV_STEPS = 31;
  localparam logic signed [SCORE_W-1:0] THRESHOLD_RESET = 16'sd26214;

  typedef enum logic [2:0] {
    ST_ENROLLED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_MATCH     = 3'd3,
    ST_NOMATCH   = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    RES_ENROLLED,
    RES_DUPLICATE,
    RES_FULL,
    RES_EMPTY,
    RES_AUTH
  } res_sel_t;

  typedef struct packed {
    logic             load_in;
    logic             mul_en;
    logic             mul_tmpl;
    logic             sum_en;
    logic             sqrt_start;
    logic             keep_sf;
    logic             ram_we;
    logic [IDX_W-1:0] ram_addr;
    logic             div_init;
    logic             div_step;
    logic             score_upd;
    logic             score_first;
    logic             load_result;
    res_sel_t         res_sel;
  } cmt_cmd_t;

  typedef struct packed {
    logic user_eq;
    logic sqrt_done;
  } cmt_stat_t;

endpackage

// ===== hdl/cosine_template_matcher_unit.sv =====
// Nearest-template matcher by cosine similarity. An enroll item (cmd 0) checks
// the table for its user number, one entry at a time; if the user is new and
// the table is not full, it takes a 32-step square root of its summed squared
// features and stores the template. An authenticate item (cmd 1) takes the root
// of its own magnitude and then scores each template in turn with the 31-step
// restoring divider. One item is worked at a time; a finished result sits in the
// output register while the next item is taken. Items that need no scan
// (authenticate on an empty table) go straight to the result state, which waits
// for the output register to be free.
module cosine_template_matcher_unit
  import cmt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      cmd,
  input  logic [USER_W-1:0]         user_id,
  input  logic signed [FEAT_W-1:0]  feature_a,
  input  logic signed [FEAT_W-1:0]  feature_b,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                status,
  output logic [USER_W-1:0]         matched_user,
  output logic signed [SCORE_W-1:0] best_score,
  input  logic                      cfg_we,
  input  logic signed [SCORE_W-1:0] cfg_data
);

  cmt_cmd_t  ctl;
  cmt_stat_t stat;

  cmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd_in    (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (ctl)
  );

  cmt_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (ctl),
    .stat         (stat),
    .user_id      (user_id),
    .feature_a    (feature_a),
    .feature_b    (feature_b),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .status       (status),
    .matched_user (matched_user),
    .best_score   (best_score)
  );

endmodule

// ===== hdl/cmt_ram.sv =====
module cmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                           wdata,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write through one port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/cmt_sqrt.sv =====
module cmt_sqrt
  import cmt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_SQ_W = $clog2(ROOT_W);

  logic [REM_W-1:0]    rem;
  logic [RAD_W-1:0]    nsh;
  logic [CNT_SQ_W-1:0] cnt;
  logic                busy;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;

  // bring down the next two radicand bits and try the next root bit
  assign rem_sh = {rem[REM_W-3:0], nsh[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  // one root bit per cycle, most significant first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        root <= '0;
        nsh  <= radicand;
      end else if (busy) begin
        nsh <= {nsh[RAD_W-3:0], 2'b00};
        cnt <= cnt + 1'b1;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        if (cnt == CNT_SQ_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/cmt_datapath.sv =====
module cmt_datapath
  import cmt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cmt_cmd_t                  cmd,
  output cmt_stat_t                 stat,
  input  logic [USER_W-1:0]         user_id,
  input  logic signed [FEAT_W-1:0]  feature_a,
  input  logic signed [FEAT_W-1:0]  feature_b,
  input  logic                      cfg_we,
  input  logic signed [SCORE_W-1:0] cfg_data,
  output logic [2:0]                status,
  output logic [USER_W-1:0]         matched_user,
  output logic signed [SCORE_W-1:0] best_score
);

  localparam int PROD_W = 2 * FEAT_W;
  localparam int SUM_W = PROD_W + 1;
  localparam int R_W = RAD_W + 1;

  logic [USER_W-1:0]         uid_r;
  logic signed [FEAT_W-1:0]  fa_r;
  logic signed [FEAT_W-1:0]  fb_r;
  logic signed [SCORE_W-1:0] thr;
  logic [ENTRY_W-1:0]        rdata;
  logic [ENTRY_W-1:0]        wdata;
  logic [USER_W-1:0]         t_user;
  logic signed [FEAT_W-1:0]  t_a;
  logic signed [FEAT_W-1:0]  t_b;
  logic [ROOT_W-1:0]         t_s;
  logic signed [FEAT_W-1:0]  ma;
  logic signed [FEAT_W-1:0]  mb;
  logic signed [PROD_W-1:0]  pa;
  logic signed [PROD_W-1:0]  pb;
  logic [RAD_W-1:0]          dprod;
  logic signed [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]          ad;
  logic [ROOT_W-1:0]         root;
  logic                      sqrt_done;
  logic [ROOT_W-1:0]         sf_r;
  logic [RAD_W-1:0]          d_r;
  logic [R_W-1:0]            r;
  logic [R_W-1:0]            r2;
  logic [DIV_STEPS-1:0]      q;
  logic                      sat;
  logic                      neg;
  logic                      zero;
  logic signed [SCORE_W-1:0] score;
  logic [SCORE_W:0]          neg_v;
  logic signed [SCORE_W-1:0] best;
  logic [USER_W-1:0]         buser;

  // template store: user, two features, scaled magnitude root
  assign wdata = {uid_r, fa_r, fb_r, root};
  assign {t_user, t_a, t_b, t_s} = rdata;

  cmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TEMPLATES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .addr  (cmd.ram_addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  cmt_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand ({sum_r[PROD_W-1:0], 16'h0000}),
    .root     (root),
    .done     (sqrt_done)
  );

  assign stat = {(t_user == uid_r), sqrt_done};

  // hold the threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  // capture the item, multiply, sum
  assign ma = cmd.mul_tmpl ? t_a : fa_r;
  assign mb = cmd.mul_tmpl ? t_b : fb_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      uid_r <= user_id;
      fa_r  <= feature_a;
      fb_r  <= feature_b;
    end
    if (cmd.mul_en) begin
      pa    <= ma * fa_r;
      pb    <= mb * fb_r;
      dprod <= t_s * sf_r;
    end
    if (cmd.sum_en) begin
      sum_r <= SUM_W'(pa) + SUM_W'(pb);
    end
    if (cmd.keep_sf) begin
      sf_r <= root;
    end
  end

  // restoring division of |dot| * 2^31 by the magnitude product
  assign ad = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign r2 = {r[R_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      d_r  <= dprod;
      r    <= R_W'(ad);
      q    <= '0;
      sat  <= (RAD_W'(ad) >= dprod);
      neg  <= sum_r[SUM_W-1];
      zero <= (dprod == '0);
    end else if (cmd.div_step) begin
      if (r2 >= R_W'(d_r)) begin
        r <= r2 - R_W'(d_r);
        q <= {q[DIV_STEPS-2:0], 1'b1};
      end else begin
        r <= r2;
        q <= {q[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  // saturate the quotient to signed Q1.15
  assign neg_v = (SCORE_W + 1)'(0) - q[SCORE_W:0];

  always_comb begin
    if (zero) begin
      score = '0;
    end else if (neg) begin
      if (sat || (q > DIV_STEPS'(32768))) begin
        score = 16'sh8000;
      end else begin
        score = neg_v[SCORE_W-1:0];
      end
    end else begin
      if (sat || (q > DIV_STEPS'(32767))) begin
        score = 16'sh7FFF;
      end else begin
        score = q[SCORE_W-1:0];
      end
    end
  end

  // keep the first best score and its user
  always_ff @(posedge clk) begin
    if (cmd.score_upd && (cmd.score_first || (score > best))) begin
      best  <= score;
      buser <= t_user;
    end
  end

  // form the result item
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      matched_user <= '0;
      best_score   <= 16'sh8000;
      case (cmd.res_sel)
        RES_ENROLLED:  status <= ST_ENROLLED;
        RES_DUPLICATE: status <= ST_DUPLICATE;
        RES_FULL:      status <= ST_FULL;
        RES_EMPTY:     status <= ST_EMPTY;
        RES_AUTH: begin
          best_score <= best;
          if (best >= thr) begin
            status       <= ST_MATCH;
            matched_user <= buser;
          end else begin
            status <= ST_NOMATCH;
          end
        end
        default:       status <= ST_EMPTY;
      endcase
    end
  end

endmodule

// ===== hdl/cmt_ctrl.sv =====
`include "cosine_template_matcher_unit_assert.svh"

module cmt_ctrl
  import cmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      cmd_in,
  output logic      out_valid,
  input  logic      out_ready,
  input  cmt_stat_t stat,
  output cmt_cmd_t  cmd
);

  localparam int DCNT_W = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    IDLE, E_RD, E_CMP, E_CHK, MAG_MUL, MAG_SUM, SQ_GO, SQ_WAIT, E_WR,
    A_RD, A_MUL, A_SUM, A_INIT, A_DIV, A_UPD, FIN
  } state_t;

  state_t            state;
  logic              auth;
  logic              dup;
  logic              first;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  idx_next;
  logic [DCNT_W-1:0] dcnt;
  res_sel_t          res_sel;
  logic              accept;
  logic              slot_free;

  assign in_ready  = (state == IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign idx_next  = idx + 1'b1;

  // decode commands from the state
  always_comb begin
    cmd             = '0;
    cmd.res_sel     = res_sel;
    cmd.ram_addr    = (state == E_WR) ? count[IDX_W-1:0] : idx[IDX_W-1:0];
    cmd.load_in     = accept;
    cmd.mul_en      = (state == MAG_MUL) || (state == A_MUL);
    cmd.mul_tmpl    = (state == A_MUL);
    cmd.sum_en      = (state == MAG_SUM) || (state == A_SUM);
    cmd.sqrt_start  = (state == SQ_GO);
    cmd.keep_sf     = (state == SQ_WAIT) && stat.sqrt_done && auth;
    cmd.ram_we      = (state == E_WR);
    cmd.div_init    = (state == A_INIT);
    cmd.div_step    = (state == A_DIV);
    cmd.score_upd   = (state == A_UPD);
    cmd.score_first = first;
    cmd.load_result = (state == FIN) && slot_free;
  end

  // sequence the item and hold the result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      auth      <= 1'b0;
      dup       <= 1'b0;
      first     <= 1'b0;
      idx       <= '0;
      dcnt      <= '0;
      res_sel   <= RES_EMPTY;
    end else begin
      if ((state == FIN) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            auth <= cmd_in;
            idx  <= '0;
            dup  <= 1'b0;
            if (!cmd_in) begin
              state <= (count == '0) ? E_CHK : E_RD;
            end else if (count == '0) begin
              res_sel <= RES_EMPTY;
              state   <= FIN;
            end else begin
              state <= MAG_MUL;
            end
          end
        end
        E_RD: state <= E_CMP;
        E_CMP: begin
          if (stat.user_eq) begin
            dup <= 1'b1;
          end
          idx   <= idx_next;
          state <= (idx_next == count) ? E_CHK : E_RD;
        end
        E_CHK: begin
          if (dup) begin
            res_sel <= RES_DUPLICATE;
            state   <= FIN;
          end else if (count == CNT_W'(MAX_TEMPLATES)) begin
            res_sel <= RES_FULL;
            state   <= FIN;
          end else begin
            state <= MAG_MUL;
          end
        end
        MAG_MUL: state <= MAG_SUM;
        MAG_SUM: state <= SQ_GO;
        SQ_GO:   state <= SQ_WAIT;
        SQ_WAIT: begin
          if (stat.sqrt_done) begin
            idx   <= '0;
            first <= 1'b1;
            state <= auth ? A_RD : E_WR;
          end
        end
        E_WR: begin
          count   <= count + 1'b1;
          res_sel <= RES_ENROLLED;
          state   <= FIN;
        end
        A_RD:  state <= A_MUL;
        A_MUL: state <= A_SUM;
        A_SUM: state <= A_INIT;
        A_INIT: begin
          dcnt  <= '0;
          state <= A_DIV;
        end
        A_DIV: begin
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCNT_W'(DIV_STEPS - 1)) begin
            state <= A_UPD;
          end
        end
        A_UPD: begin
          first <= 1'b0;
          idx   <= idx_next;
          if (idx_next == count) begin
            res_sel <= RES_AUTH;
            state   <= FIN;
          end else begin
            state <= A_RD;
          end
        end
        FIN: begin
          if (slot_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `CMT_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(MAX_TEMPLATES), "count overrun")
  `CMT_ASSERT_IMPL(a_write_room, clk, rst, cmd.ram_we, count < CNT_W'(MAX_TEMPLATES), "write when full")
  `CMT_ASSERT_IMPL(a_result_slot, clk, rst, cmd.load_result, slot_free, "result overwritten")
  `CMT_ASSERT_NEXT(a_one_item, clk, rst, accept, !in_ready, "second item taken")

endmodule

// ===== tb/cmt_checker.sv =====
`timescale 1ns / 100ps
module cmt_checker
  import cmt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      cmd,
  input  logic [USER_W-1:0]         user_id,
  input  logic signed [FEAT_W-1:0]  feature_a,
  input  logic signed [FEAT_W-1:0]  feature_b,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [2:0]                status,
  input  logic [USER_W-1:0]         matched_user,
  input  logic signed [SCORE_W-1:0] best_score,
  input  logic                      cfg_we,
  input  logic signed [SCORE_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending
);

  typedef struct {
    status_t                   st;
    logic [USER_W-1:0]         user;
    logic signed [SCORE_W-1:0] score;
  } verdict_t;

  // mirror of the block's template table and threshold
  logic [USER_W-1:0]         tbl_user [MAX_TEMPLATES];
  logic signed [FEAT_W-1:0]  tbl_fa [MAX_TEMPLATES];
  logic signed [FEAT_W-1:0]  tbl_fb [MAX_TEMPLATES];
  int                        tbl_count;
  logic signed [SCORE_W-1:0] threshold;
  verdict_t                  verdicts_due [$];

  assign pending = verdicts_due.size();

  // bitwise integer square root, rounded down
  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // cosine similarity of a template and a probe, Q1.15, saturated
  function automatic int cosine_q15(logic signed [FEAT_W-1:0] ta,
                                    logic signed [FEAT_W-1:0] tb,
                                    logic signed [FEAT_W-1:0] fa,
                                    logic signed [FEAT_W-1:0] fb);
    longint      dot;
    logic [63:0] mt;
    logic [63:0] mf;
    logic [63:0] d;
    logic [63:0] ad;
    logic [63:0] q;
    logic [63:0] r;
    dot = longint'(ta) * longint'(fa) + longint'(tb) * longint'(fb);
    mt  = longint'(ta) * longint'(ta) + longint'(tb) * longint'(tb);
    mf  = longint'(fa) * longint'(fa) + longint'(fb) * longint'(fb);
    d   = floor_root(mt << 16) * floor_root(mf << 16);
    if (d == 0) return 0;
    ad = (dot < 0) ? 64'(-dot) : 64'(dot);
    if (ad / d != 0) begin
      q = 64'hFFFF_FFFF;
    end else begin
      q = 0;
      r = ad;
      for (int i = 0; i < DIV_STEPS; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 64'd1;
        end
      end
    end
    if (dot < 0) return (q > 32768) ? -32768 : -int'(q);
    return (q > 32767) ? 32767 : int'(q);
  endfunction

  // apply one item to the mirror and give its verdict
  function automatic verdict_t judge_item(logic c, logic [USER_W-1:0] uid,
                                          logic signed [FEAT_W-1:0] fa,
                                          logic signed [FEAT_W-1:0] fb);
    verdict_t v;
    int       best;
    int       s;
    v.st    = ST_ENROLLED;
    v.user  = '0;
    v.score = 16'sh8000;
    if (c == 1'b0) begin
      for (int i = 0; i < tbl_count; i++)
        if (tbl_user[i] == uid) v.st = ST_DUPLICATE;
      if (v.st == ST_ENROLLED) begin
        if (tbl_count >= MAX_TEMPLATES) begin
          v.st = ST_FULL;
        end else begin
          tbl_user[tbl_count] = uid;
          tbl_fa[tbl_count]   = fa;
          tbl_fb[tbl_count]   = fb;
          tbl_count++;
        end
      end
    end else if (tbl_count == 0) begin
      v.st = ST_EMPTY;
    end else begin
      best   = cosine_q15(tbl_fa[0], tbl_fb[0], fa, fb);
      v.user = tbl_user[0];
      for (int i = 1; i < tbl_count; i++) begin
        s = cosine_q15(tbl_fa[i], tbl_fb[i], fa, fb);
        if (s > best) begin
          best   = s;
          v.user = tbl_user[i];
        end
      end
      v.score = best[SCORE_W-1:0];
      if (best >= int'(threshold)) begin
        v.st = ST_MATCH;
      end else begin
        v.st   = ST_NOMATCH;
        v.user = '0;
      end
    end
    return v;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t checker: %s", $realtime, what);
    fail_count++;
  endtask

  initial fail_count = 0;

  // match each result transfer, then take in the new item
  always @(posedge clk) begin
    verdict_t v;
    if (rst) begin
      tbl_count = 0;
      threshold = THRESHOLD_RESET;
      verdicts_due.delete();
    end else begin
      if (cfg_we) threshold = cfg_data;
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("result with nothing outstanding");
        end else begin
          v = verdicts_due.pop_front();
          if (status !== v.st)
            report_mismatch($sformatf("status %0d, want %0d", status, v.st));
          if (matched_user !== v.user)
            report_mismatch($sformatf("matched_user %0d, want %0d",
                                      matched_user, v.user));
          if (best_score !== v.score)
            report_mismatch($sformatf("best_score %0d, want %0d",
                                      best_score, v.score));
        end
      end
      if (in_valid && in_ready)
        verdicts_due = {verdicts_due, judge_item(cmd, user_id, feature_a, feature_b)};
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb
  import cmt_pkg::*;
;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 830;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic                      cmd;
  logic [USER_W-1:0]         user_id;
  logic signed [FEAT_W-1:0]  feature_a;
  logic signed [FEAT_W-1:0]  feature_b;
  logic                      out_valid;
  logic                      out_ready;
  logic [2:0]                status;
  logic [USER_W-1:0]         matched_user;
  logic signed [SCORE_W-1:0] best_score;
  logic                      cfg_we;
  logic signed [SCORE_W-1:0] cfg_data;
  int                        fail_count;
  int                        pending;
  int                        cycles;
  logic                      no_gaps;

  // stimulus-side copy of the table, used to aim probes and duplicates
  logic [USER_W-1:0]         known_user [MAX_TEMPLATES];
  logic signed [FEAT_W-1:0]  known_fa [MAX_TEMPLATES];
  logic signed [FEAT_W-1:0]  known_fb [MAX_TEMPLATES];
  int                        known_count;

  cosine_template_matcher_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .user_id(user_id), .feature_a(feature_a), .feature_b(feature_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .matched_user(matched_user), .best_score(best_score),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  cmt_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .user_id(user_id), .feature_a(feature_a), .feature_b(feature_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .matched_user(matched_user), .best_score(best_score),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop on a hung run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // result side: stall a random number of cycles before each transfer
  initial begin
    int k;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      k = no_gaps ? 0 : $urandom_range(0, 12);
      if (k > 0) begin
        out_ready = 1'b0;
        repeat (k) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // present one item, hold it until transfer, then idle a random while
  task automatic send_item(logic c, logic [USER_W-1:0] uid,
                           logic signed [FEAT_W-1:0] fa,
                           logic signed [FEAT_W-1:0] fb);
    int  k;
    bit  seen;
    cmd       = c;
    user_id   = uid;
    feature_a = fa;
    feature_b = fb;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    // track what the block will have stored
    if (c == 1'b0) begin
      seen = 0;
      for (int i = 0; i < known_count; i++)
        if (known_user[i] == uid) seen = 1;
      if (!seen && known_count < MAX_TEMPLATES) begin
        known_user[known_count] = uid;
        known_fa[known_count]   = fa;
        known_fb[known_count]   = fb;
        known_count++;
      end
    end
    k = no_gaps ? 0 : $urandom_range(0, 12);
    if (k > 0) begin
      in_valid = 1'b0;
      repeat (k) @(negedge clk);
    end
  endtask

  // drain all outstanding results, then write the threshold
  task automatic set_threshold(logic signed [SCORE_W-1:0] value);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_data = value;
    cfg_we   = 1'b1;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  // probe features: random, near a template, mirrored, scaled down, or corner values
  task automatic pick_features(output logic signed [FEAT_W-1:0] fa,
                               output logic signed [FEAT_W-1:0] fb);
    int j;
    case ($urandom_range(0, 5))
      0, 1: begin
        fa = FEAT_W'($urandom);
        fb = FEAT_W'($urandom);
      end
      2: begin
        j  = (known_count > 0) ? $urandom_range(0, known_count - 1) : 0;
        fa = known_fa[j] + FEAT_W'($urandom_range(0, 64)) - 24'sd32;
        fb = known_fb[j] + FEAT_W'($urandom_range(0, 64)) - 24'sd32;
      end
      3: begin
        j  = (known_count > 0) ? $urandom_range(0, known_count - 1) : 0;
        fa = -known_fa[j];
        fb = -known_fb[j];
      end
      4: begin
        j  = (known_count > 0) ? $urandom_range(0, known_count - 1) : 0;
        fa = known_fa[j] >>> $urandom_range(0, 6);
        fb = known_fb[j] >>> $urandom_range(0, 6);
      end
      default: begin
        fa = $urandom_range(0, 3) == 0 ? 24'sh800000 :
             $urandom_range(0, 1) == 0 ? 24'sh7FFFFF : FEAT_W'($urandom_range(0, 3));
        fb = $urandom_range(0, 3) == 0 ? 24'sh800000 :
             $urandom_range(0, 1) == 0 ? -24'sd1 : FEAT_W'($urandom_range(0, 3));
      end
    endcase
  endtask

  initial begin
    logic signed [FEAT_W-1:0] fa;
    logic signed [FEAT_W-1:0] fb;
    logic [USER_W-1:0]        uid;
    rst         = 1'b1;
    in_valid    = 1'b0;
    cmd         = 1'b0;
    user_id     = '0;
    feature_a   = '0;
    feature_b   = '0;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    no_gaps     = 1'b0;
    known_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty table, corner features, duplicates, zero vectors, threshold settings
    send_item(1'b1, 8'd0, 24'sd256, 24'sd256);
    send_item(1'b0, 8'd0, 24'sd0, 24'sd0);
    send_item(1'b1, 8'd9, 24'sd100, 24'sd0);
    send_item(1'b0, 8'd255, 24'sh7FFFFF, 24'sh7FFFFF);
    send_item(1'b0, 8'd255, 24'sd1, 24'sd1);
    send_item(1'b0, 8'd1, 24'sh800000, 24'sh800000);
    send_item(1'b0, 8'd2, 24'sd1, -24'sd1);
    send_item(1'b1, 8'd0, 24'sd0, 24'sd0);
    send_item(1'b1, 8'hFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_item(1'b1, 8'd0, 24'sh800000, 24'sh800000);
    send_item(1'b1, 8'd0, 24'sh800000, 24'sh7FFFFF);
    send_item(1'b1, 8'd0, -24'sd1, 24'sd1);
    set_threshold(16'sh8000);
    send_item(1'b1, 8'd0, 24'sd3, -24'sd5);
    set_threshold(16'sh7FFF);
    send_item(1'b1, 8'd0, 24'sd5, 24'sd5);
    set_threshold(16'sd0);
    send_item(1'b1, 8'd0, 24'sd0, 24'sd7);

    // random: mostly authentication, with enrolls that fill the table early
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 170 == 169) begin
        case ((n / 170) % 4)
          0: set_threshold(16'sh8000);
          1: set_threshold(16'sh7FFF);
          2: set_threshold(SCORE_W'($urandom));
          default: set_threshold(THRESHOLD_RESET);
        endcase
      end
      no_gaps = ((n / 60) % 3 == 2);
      pick_features(fa, fb);
      if ($urandom_range(0, 3) == 0) begin
        uid = (known_count > 0 && $urandom_range(0, 2) == 0) ?
              known_user[$urandom_range(0, known_count - 1)] : USER_W'($urandom);
        send_item(1'b0, uid, fa, fb);
      end else begin
        send_item(1'b1, USER_W'($urandom), fa, fb);
      end
    end

    // wind down
    in_valid = 1'b0;
    no_gaps  = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (700) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== cosine_template_matcher_unit.f =====
+incdir+hdl
hdl/cmt_pkg.sv
hdl/cmt_ram.sv
hdl/cmt_sqrt.sv
hdl/cmt_datapath.sv
hdl/cmt_ctrl.sv
hdl/cosine_template_matcher_unit.sv
tb/cmt_checker.sv
tb/tb.sv
